// ===== design/stmdr_pkg.sv =====
package stmdr_pkg;

   localparam int ID_W       = 8;
   localparam int DENS_W     = 8;
   localparam int TILE_IDX_W = 10;
   localparam int SLOT_NUM_W = 2;

   localparam logic [ID_W-1:0] INVALID_ID_RESET = 8'hFF;

   typedef enum logic [1:0] {
      OP_SET   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   typedef struct packed {
      logic [SLOT_NUM_W-1:0] slot_number;
      logic                  slot_written;
      logic [DENS_W-1:0]     density_read;
      logic                  edit_event;
      logic [TILE_IDX_W-1:0] tile_out;
   } rsp_type;

endpackage

// ===== design/slot_table_min_density_replace_core.sv =====
// A request is taken into stage s1 while its tile entry is read; its response is registered
// into rsp_ff when s1 moves on, and is held there until rsp_tready is high.
// Throughput: one request per cycle unless rsp_tready stalls; one read-modify-write of a tile
// entry per request through a single-port-write store, forwarding the same tile back to back.
// Reset: synchronous; a clearing pass then sets every tile to free slots,
// with req_tready low throughout; csr writes are taken at all times outside reset.
module slot_table_min_density_replace_core #(
   parameter int TILES = 1024,
   parameter int SLOTS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // tile_index[9:0], grass_id[17:10], density[25:18]
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // tile_out[9:0], edit_event[10], density_read[18:11],
                                    // slot_written[19], slot_number[21:20]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_wdata    // invalid_id[7:0]
);

   localparam int AW      = $clog2(TILES);
   localparam int TW      = stmdr_pkg::TILE_IDX_W;
   localparam int W       = 2 * SLOTS * stmdr_pkg::ID_W;
   localparam int PW      = TW + 17;
   localparam int RECIP   = (1 << 20) / TILES;
   localparam logic [16:0] RECIP_W = 17'(RECIP);
   localparam logic [PW-1:0] TILES_P = PW'(TILES);

   logic [TW-1:0]                   req_tile;
   logic [stmdr_pkg::ID_W-1:0]      req_gid;
   logic [stmdr_pkg::DENS_W-1:0]    req_dens;
   logic [PW-1:0]                   mod_prod;
   logic [PW-1:0]                   mod_q;
   logic [PW-1:0]                   mod_r;
   logic [PW-1:0]                   mod_rc;
   logic [AW-1:0]                   req_addr;
   logic                            req_fire;

   logic                            clearing;
   logic [W-1:0]                    tile_q;
   logic [W-1:0]                    tile_d;
   logic                            tile_we;
   stmdr_pkg::rsp_type              upd_rsp;

   logic                            s1_valid_ff, s1_valid_in;
   logic                            s1_fire;
   logic [1:0]                      s1_op_ff;
   logic [TW-1:0]                   s1_tile_ff;
   logic [stmdr_pkg::ID_W-1:0]      s1_gid_ff;
   logic [stmdr_pkg::DENS_W-1:0]    s1_dens_ff;
   logic [AW-1:0]                   s1_addr_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   stmdr_pkg::rsp_type              rsp_ff;
   logic [stmdr_pkg::ID_W-1:0]      invalid_id_ff, invalid_id_in;

   assign req_tile = req_tdata[9:0];
   assign req_gid  = req_tdata[17:10];
   assign req_dens = req_tdata[25:18];

   // tile index modulo TILES by reciprocal multiply and one correction
   always_comb begin
      mod_prod = {17'b0, req_tile} * {{TW{1'b0}}, RECIP_W};
      mod_q    = {20'b0, mod_prod[PW-1:20]};
      mod_r    = {17'b0, req_tile} - (mod_q * TILES_P);
      mod_rc   = (mod_r >= TILES_P) ? (mod_r - TILES_P) : mod_r;
      req_addr = mod_rc[AW-1:0];
   end

   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clearing && (!s1_valid_ff || s1_fire);
   assign req_fire   = req_tvalid && req_tready;

   stmdr_store #(
      .TILES(TILES),
      .SLOTS(SLOTS),
      .AW   (AW)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .clearing(clearing),
      .rd_en   (req_fire),
      .rd_addr (req_addr),
      .rd_data (tile_q),
      .wr_en   (s1_fire && tile_we),
      .wr_addr (s1_addr_ff),
      .wr_data (tile_d)
   );

   stmdr_update #(
      .SLOTS(SLOTS)
   ) u_update (
      .op        (s1_op_ff),
      .tile_index(s1_tile_ff),
      .grass_id  (s1_gid_ff),
      .density   (s1_dens_ff),
      .invalid_id(invalid_id_ff),
      .tile_q    (tile_q),
      .tile_we   (tile_we),
      .tile_d    (tile_d),
      .rsp       (upd_rsp)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      invalid_id_in = csr_valid ? csr_wdata : invalid_id_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         invalid_id_ff <= stmdr_pkg::INVALID_ID_RESET;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         invalid_id_ff <= invalid_id_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff   <= req_tuser;
         s1_tile_ff <= req_tile;
         s1_gid_ff  <= req_gid;
         s1_dens_ff <= req_dens;
         s1_addr_ff <= req_addr;
      end
      if (s1_fire) begin
         rsp_ff <= upd_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff};
   assign csr_ready  = 1'b1;

endmodule

// ===== design/stmdr_store.sv =====
module stmdr_store #(
   parameter int TILES = 1024,
   parameter int SLOTS = 4,
   parameter int AW    = 10
) (
   input  logic                                    clock,
   input  logic                                    reset,
   output logic                                    clearing,
   input  logic                                    rd_en,
   input  logic [AW-1:0]                           rd_addr,
   output logic [2*SLOTS*stmdr_pkg::ID_W-1:0]      rd_data,
   input  logic                                    wr_en,
   input  logic [AW-1:0]                           wr_addr,
   input  logic [2*SLOTS*stmdr_pkg::ID_W-1:0]      wr_data
);

   localparam int HALF_W = SLOTS * stmdr_pkg::ID_W;
   localparam int W      = 2 * HALF_W;
   localparam logic [W-1:0] CLEAR_WORD =
      {{HALF_W{1'b0}}, {SLOTS{stmdr_pkg::INVALID_ID_RESET}}};

   logic [W-1:0]  mem_ff [TILES];
   logic [W-1:0]  ram_q_ff;
   logic [W-1:0]  fwd_data_ff, fwd_data_in;
   logic          fwd_hit_ff, fwd_hit_in;
   logic          clearing_ff, clearing_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [W-1:0]  mem_wd;

   always_comb begin
      mem_we = clearing_ff | wr_en;
      mem_wa = clearing_ff ? clr_addr_ff : wr_addr;
      mem_wd = clearing_ff ? CLEAR_WORD : wr_data;

      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(TILES - 1)) begin
            clearing_in = 1'b0;
         end
      end

      fwd_hit_in  = fwd_hit_ff;
      fwd_data_in = fwd_data_ff;
      if (rd_en) begin
         fwd_hit_in  = wr_en && (wr_addr == rd_addr);
         fwd_data_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         ram_q_ff <= mem_ff[rd_addr];
      end
      fwd_data_ff <= fwd_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
         fwd_hit_ff  <= fwd_hit_in;
      end
   end

   assign clearing = clearing_ff;
   assign rd_data  = fwd_hit_ff ? fwd_data_ff : ram_q_ff;

endmodule

// ===== design/stmdr_update.sv =====
module stmdr_update #(
   parameter int SLOTS = 4
) (
   input  logic [1:0]                              op,
   input  logic [stmdr_pkg::TILE_IDX_W-1:0]        tile_index,
   input  logic [stmdr_pkg::ID_W-1:0]              grass_id,
   input  logic [stmdr_pkg::DENS_W-1:0]            density,
   input  logic [stmdr_pkg::ID_W-1:0]              invalid_id,
   input  logic [2*SLOTS*stmdr_pkg::ID_W-1:0]      tile_q,
   output logic                                    tile_we,
   output logic [2*SLOTS*stmdr_pkg::ID_W-1:0]      tile_d,
   output stmdr_pkg::rsp_type                      rsp
);

   localparam int IW     = stmdr_pkg::ID_W;
   localparam int DW     = stmdr_pkg::DENS_W;
   localparam int HALF_W = SLOTS * IW;
   localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [IW-1:0]      ids  [SLOTS];
   logic [DW-1:0]      dens [SLOTS];
   logic [IW-1:0]      ids_d  [SLOTS];
   logic [DW-1:0]      dens_d [SLOTS];
   logic [SLOTS-1:0]   hit;
   logic [SLOTS-1:0]   lowest;
   logic               found;
   logic [SW-1:0]      hit_idx;
   logic [SW-1:0]      low_idx;
   logic [SW-1:0]      wr_idx;
   logic [SW+1:0]      wr_idx_ext;
   logic               written;
   logic [DW-1:0]      dens_rd;

   always_comb begin
      for (int s = 0; s < SLOTS; s++) begin
         ids[s]  = tile_q[s*IW +: IW];
         dens[s] = tile_q[HALF_W + s*DW +: DW];
         hit[s]  = (ids[s] == grass_id);
      end

      // first matching slot
      found   = 1'b0;
      hit_idx = '0;
      for (int s = 0; s < SLOTS; s++) begin
         if (hit[s] && !found) begin
            found   = 1'b1;
            hit_idx = SW'(s);
         end
      end

      // first slot of lowest density
      for (int s = 0; s < SLOTS; s++) begin
         lowest[s] = 1'b1;
         for (int j = 0; j < SLOTS; j++) begin
            if (j < s && !(dens[s] < dens[j])) begin
               lowest[s] = 1'b0;
            end
            if (j > s && !(dens[s] <= dens[j])) begin
               lowest[s] = 1'b0;
            end
         end
      end
      low_idx = '0;
      for (int s = 0; s < SLOTS; s++) begin
         if (lowest[s]) begin
            low_idx = SW'(s);
         end
      end

      for (int s = 0; s < SLOTS; s++) begin
         ids_d[s]  = ids[s];
         dens_d[s] = dens[s];
      end
      tile_we = 1'b0;
      written = 1'b0;
      wr_idx  = '0;
      dens_rd = '0;

      unique case (op)
         stmdr_pkg::OP_SET: begin
            if (found) begin
               tile_we         = 1'b1;
               written         = 1'b1;
               wr_idx          = hit_idx;
               dens_d[hit_idx] = density;
               if (density == '0) begin
                  ids_d[hit_idx] = invalid_id;
               end
            end else if (density != '0) begin
               tile_we         = 1'b1;
               written         = 1'b1;
               wr_idx          = low_idx;
               dens_d[low_idx] = density;
               ids_d[low_idx]  = grass_id;
            end
         end
         stmdr_pkg::OP_CLEAR: begin
            tile_we = 1'b1;
            for (int s = 0; s < SLOTS; s++) begin
               ids_d[s]  = invalid_id;
               dens_d[s] = '0;
            end
         end
         stmdr_pkg::OP_QUERY: begin
            if (found) begin
               dens_rd = dens[hit_idx];
            end
         end
         default: begin
         end
      endcase

      for (int s = 0; s < SLOTS; s++) begin
         tile_d[s*IW +: IW]          = ids_d[s];
         tile_d[HALF_W + s*DW +: DW] = dens_d[s];
      end

      wr_idx_ext       = {2'b00, wr_idx};
      rsp.tile_out     = tile_index;
      rsp.edit_event   = (op == stmdr_pkg::OP_SET) || (op == stmdr_pkg::OP_CLEAR);
      rsp.density_read = dens_rd;
      rsp.slot_written = written;
      rsp.slot_number  = wr_idx_ext[stmdr_pkg::SLOT_NUM_W-1:0];
   end

endmodule
